FILE: hw/rtl/sensor_duty_cycle_sampler_core_macros.svh
// Assertion macros shared by the duty-cycle sampler RTL.
`ifndef SENSOR_DUTY_CYCLE_SAMPLER_CORE_MACROS_SVH
`define SENSOR_DUTY_CYCLE_SAMPLER_CORE_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define SDCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition at one edge implies a consequence at the next edge.
`define SDCS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: hw/rtl/sdcs_pkg.sv
// Types and constants of the particle-sensor duty-cycle sampler.
package sdcs_pkg;

  // Item kinds carried in the input tuser field.
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_SENT = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_CYCLE_PERIOD    = 3'd0;
  localparam logic [2:0] REG_WARMUP_TIME     = 3'd1;
  localparam logic [2:0] REG_SAMPLE_TIME     = 3'd2;
  localparam logic [2:0] REG_POLL_PERIOD     = 3'd3;
  localparam logic [2:0] REG_MIN_GOOD_FRAMES = 3'd4;
  localparam logic [2:0] REG_SENSOR_PRESENT  = 3'd5;

  localparam int CFG_BITS   = 20;
  localparam int COUNT_BITS = 8;
  localparam int PM_BITS    = 16;

  // Reset values of the configuration registers.
  localparam logic [CFG_BITS-1:0]   RST_CYCLE_PERIOD    = 20'd300000;
  localparam logic [CFG_BITS-1:0]   RST_WARMUP_TIME     = 20'd30000;
  localparam logic [CFG_BITS-1:0]   RST_SAMPLE_TIME     = 20'd8000;
  localparam logic [CFG_BITS-1:0]   RST_POLL_PERIOD     = 20'd1000;
  localparam logic [COUNT_BITS-1:0] RST_MIN_GOOD_FRAMES = 8'd2;

  localparam logic [COUNT_BITS-1:0] GOOD_MAX = 8'd255;

  // Phase codes as reported in the result.
  localparam logic [1:0] PHASE_CODE_SLEEP  = 2'd0;
  localparam logic [1:0] PHASE_CODE_WARM   = 2'd1;
  localparam logic [1:0] PHASE_CODE_SAMPLE = 2'd2;

  typedef enum logic [2:0] {
    PH_SLEEP  = 3'b001,
    PH_WARM   = 3'b010,
    PH_SAMPLE = 3'b100
  } phase_t;

  // One result item, packed exactly as it leaves on m_tdata.
  typedef struct packed {
    logic               pad;
    logic [PM_BITS-1:0] pm10;
    logic [PM_BITS-1:0] pm25;
    logic [PM_BITS-1:0] pm1;
    logic               reading_valid;
    logic               cycle_skipped;
    logic               cycle_stored;
    logic               frame_polled;
    logic [1:0]         phase;
    logic               fan_on;
  } result_t;

  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    unique case (ph)
      PH_SLEEP:  code = PHASE_CODE_SLEEP;
      PH_WARM:   code = PHASE_CODE_WARM;
      PH_SAMPLE: code = PHASE_CODE_SAMPLE;
      default:   code = PHASE_CODE_SLEEP;
    endcase
    return code;
  endfunction

endpackage

FILE: hw/rtl/sensor_duty_cycle_sampler_core.sv
// Top level of the particle-sensor duty-cycle sampler.
//
// Items arrive on the s_* stream: s_tuser carries the item kind (tick, read
// request, mark-sent) and s_tdata the frame offered on a tick. Every accepted
// item yields exactly one result transfer on the m_* stream with the fan
// level, the phase after the item, the poll/store/skip flags and, on a valid
// read, the cached concentrations.
// The block has two register stages: an input register that holds the item
// and a result register fed by one pass of counter, compare and select logic.
// An accepted item passes through the input register and then the result
// register, which offers its result. One item is accepted per cycle while
// the receiver takes results; this rate comes from the state update, which
// closes in a single pass through that logic.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps one more item, so s_tready drops only when both are
// full. The user must write configuration via cfg_we/cfg_index/cfg_data only
// while the block is idle, unenforced by it; writes to unused indexes are ignored.
// A synchronous reset empties both stages, restores the register defaults,
// puts the sensor in warm-up with the fan on and clears counters and cache.
module sensor_duty_cycle_sampler_core #(
  parameter int TIME_BITS  = 20,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata from bit 0: frame_ok(1), frame_pm1(16), frame_pm25(16),
  // frame_pm10(16), zero fill(7).
  input  logic [55:0] s_tdata,
  // s_tuser: action(2).
  input  logic [1:0]  s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata from bit 0: fan_on(1), phase(2), frame_polled(1), cycle_stored(1),
  // cycle_skipped(1), reading_valid(1), out_pm1(16), out_pm25(16),
  // out_pm10(16), zero fill(1).
  output logic [55:0] m_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  `include "sensor_duty_cycle_sampler_core_macros.svh"

  // Compare width covers both the counters and the 20-bit registers.
  localparam int CW = (TIME_BITS > sdcs_pkg::CFG_BITS) ? TIME_BITS : sdcs_pkg::CFG_BITS;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  // Configuration registers.
  logic [sdcs_pkg::CFG_BITS-1:0]   cycle_period;
  logic [sdcs_pkg::CFG_BITS-1:0]   warmup_time;
  logic [sdcs_pkg::CFG_BITS-1:0]   sample_time;
  logic [sdcs_pkg::CFG_BITS-1:0]   poll_period;
  logic [sdcs_pkg::COUNT_BITS-1:0] min_good_frames;
  logic                            sensor_present;

  // Input register.
  logic                         in_valid;
  logic [1:0]                   in_action;
  logic                         in_ok;
  logic [sdcs_pkg::PM_BITS-1:0] in_pm1, in_pm25, in_pm10;

  // Block state.
  sdcs_pkg::phase_t                phase_state, phase_state_next;
  logic                            enable_level, enable_level_next;
  logic [TIME_BITS-1:0]            since_cycle_start, since_cycle_start_next;
  logic [TIME_BITS-1:0]            since_phase_start, since_phase_start_next;
  logic [TIME_BITS-1:0]            since_last_poll, since_last_poll_next;
  logic [TIME_BITS-1:0]            cache_age, cache_age_next;
  logic [sdcs_pkg::COUNT_BITS-1:0] good_count, good_count_next;
  logic [VALUE_BITS-1:0]           last_pm1, last_pm25, last_pm10;
  logic [VALUE_BITS-1:0]           last_pm1_next, last_pm25_next, last_pm10_next;
  logic [VALUE_BITS-1:0]           cached_pm1, cached_pm25, cached_pm10;
  logic                            cache_load;
  logic                            cache_fresh, cache_fresh_next;

  // Result register.
  logic              out_valid;
  sdcs_pkg::result_t out_data, result_next;

  logic advance;
  logic [TIME_BITS-1:0] scs_inc, sps_inc, slp_inc, age_inc;
  logic [TIME_BITS-1:0] poll_load;

  // The item in the input register moves on whenever the result register is
  // empty or its transfer completes in this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_period    <= sdcs_pkg::RST_CYCLE_PERIOD;
      warmup_time     <= sdcs_pkg::RST_WARMUP_TIME;
      sample_time     <= sdcs_pkg::RST_SAMPLE_TIME;
      poll_period     <= sdcs_pkg::RST_POLL_PERIOD;
      min_good_frames <= sdcs_pkg::RST_MIN_GOOD_FRAMES;
      sensor_present  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdcs_pkg::REG_CYCLE_PERIOD:    cycle_period    <= cfg_data;
        sdcs_pkg::REG_WARMUP_TIME:     warmup_time     <= cfg_data;
        sdcs_pkg::REG_SAMPLE_TIME:     sample_time     <= cfg_data;
        sdcs_pkg::REG_POLL_PERIOD:     poll_period     <= cfg_data;
        sdcs_pkg::REG_MIN_GOOD_FRAMES: min_good_frames <= cfg_data[sdcs_pkg::COUNT_BITS-1:0];
        sdcs_pkg::REG_SENSOR_PRESENT:  sensor_present  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_ok     <= s_tdata[0];
      in_pm1    <= s_tdata[16:1];
      in_pm25   <= s_tdata[32:17];
      in_pm10   <= s_tdata[48:33];
    end
  end

  // Elapsed counters saturate at their maximum.
  assign scs_inc = (since_cycle_start == TMAX) ? TMAX : since_cycle_start + 1'b1;
  assign sps_inc = (since_phase_start == TMAX) ? TMAX : since_phase_start + 1'b1;
  assign slp_inc = (since_last_poll == TMAX) ? TMAX : since_last_poll + 1'b1;
  assign age_inc = (cache_age == TMAX) ? TMAX : cache_age + 1'b1;

  // On entry to sampling the poll counter is primed so the first tick polls.
  assign poll_load = (CW'(poll_period) > CW'(TMAX)) ? TMAX : TIME_BITS'(poll_period);

  always_comb begin
    phase_state_next       = phase_state;
    enable_level_next      = enable_level;
    since_cycle_start_next = since_cycle_start;
    since_phase_start_next = since_phase_start;
    since_last_poll_next   = since_last_poll;
    cache_age_next         = cache_age;
    good_count_next        = good_count;
    last_pm1_next          = last_pm1;
    last_pm25_next         = last_pm25;
    last_pm10_next         = last_pm10;
    cache_load             = 1'b0;
    cache_fresh_next       = cache_fresh;
    result_next            = '0;

    case (in_action)
      sdcs_pkg::ACT_TICK: begin
        since_cycle_start_next = scs_inc;
        since_phase_start_next = sps_inc;
        since_last_poll_next   = slp_inc;
        cache_age_next         = age_inc;
        unique case (phase_state)
          sdcs_pkg::PH_SLEEP: begin
            if (CW'(scs_inc) >= CW'(cycle_period)) begin
              enable_level_next      = 1'b1;
              since_cycle_start_next = '0;
              since_phase_start_next = '0;
              phase_state_next       = sdcs_pkg::PH_WARM;
            end
          end
          sdcs_pkg::PH_WARM: begin
            if (CW'(sps_inc) >= CW'(warmup_time)) begin
              good_count_next        = '0;
              since_last_poll_next   = poll_load;
              since_phase_start_next = '0;
              phase_state_next       = sdcs_pkg::PH_SAMPLE;
            end
          end
          sdcs_pkg::PH_SAMPLE: begin
            if (CW'(slp_inc) >= CW'(poll_period)) begin
              since_last_poll_next     = '0;
              result_next.frame_polled = 1'b1;
              if (sensor_present && in_ok) begin
                last_pm1_next  = in_pm1[VALUE_BITS-1:0];
                last_pm25_next = in_pm25[VALUE_BITS-1:0];
                last_pm10_next = in_pm10[VALUE_BITS-1:0];
                if (good_count != sdcs_pkg::GOOD_MAX) begin
                  good_count_next = good_count + 1'b1;
                end
              end
            end
            if (CW'(sps_inc) >= CW'(sample_time)) begin
              // The count and frame include a poll taken on this same tick.
              if (good_count_next >= min_good_frames) begin
                cache_load               = 1'b1;
                cache_age_next           = '0;
                cache_fresh_next         = 1'b1;
                result_next.cycle_stored = 1'b1;
              end else begin
                result_next.cycle_skipped = 1'b1;
              end
              enable_level_next      = 1'b0;
              since_phase_start_next = '0;
              phase_state_next       = sdcs_pkg::PH_SLEEP;
            end
          end
          default: ;
        endcase
      end
      sdcs_pkg::ACT_READ: begin
        if (cache_fresh) begin
          if (CW'(cache_age) < CW'(cycle_period)) begin
            result_next.reading_valid = 1'b1;
            result_next.pm1           = sdcs_pkg::PM_BITS'(cached_pm1);
            result_next.pm25          = sdcs_pkg::PM_BITS'(cached_pm25);
            result_next.pm10          = sdcs_pkg::PM_BITS'(cached_pm10);
          end else begin
            // An expired cache is dropped on the read that finds it.
            cache_fresh_next = 1'b0;
          end
        end
      end
      sdcs_pkg::ACT_SENT: begin
        cache_fresh_next = 1'b0;
      end
      default: ;
    endcase

    result_next.fan_on = enable_level_next;
    result_next.phase  = sdcs_pkg::phase_code(phase_state_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_state       <= sdcs_pkg::PH_WARM;
      enable_level      <= 1'b1;
      since_cycle_start <= '0;
      since_phase_start <= '0;
      since_last_poll   <= '0;
      cache_age         <= '0;
      good_count        <= '0;
      last_pm1          <= '0;
      last_pm25         <= '0;
      last_pm10         <= '0;
      cached_pm1        <= '0;
      cached_pm25       <= '0;
      cached_pm10       <= '0;
      cache_fresh       <= 1'b0;
    end else if (advance) begin
      phase_state       <= phase_state_next;
      enable_level      <= enable_level_next;
      since_cycle_start <= since_cycle_start_next;
      since_phase_start <= since_phase_start_next;
      since_last_poll   <= since_last_poll_next;
      cache_age         <= cache_age_next;
      good_count        <= good_count_next;
      last_pm1          <= last_pm1_next;
      last_pm25         <= last_pm25_next;
      last_pm10         <= last_pm10_next;
      cache_fresh       <= cache_fresh_next;
      if (cache_load) begin
        cached_pm1  <= last_pm1_next;
        cached_pm25 <= last_pm25_next;
        cached_pm10 <= last_pm10_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

  // The fan runs exactly while the sensor is awake.
  `SDCS_ASSERT(a_fan_follows_phase, enable_level == (phase_state != sdcs_pkg::PH_SLEEP),
    "fan level disagrees with phase")
  // A sampling end either stores or skips, never both.
  `SDCS_ASSERT(a_store_xor_skip, out_valid |-> !(out_data.cycle_stored && out_data.cycle_skipped),
    "cycle both stored and skipped")
  // Concentrations leave only with a valid reading.
  `SDCS_ASSERT(a_pm_zero_when_invalid,
    (out_valid && !out_data.reading_valid) |->
      (out_data.pm1 == '0 && out_data.pm25 == '0 && out_data.pm10 == '0),
    "concentrations driven without a valid reading")
  // The cache becomes fresh only together with a stored-cycle result.
  `SDCS_ASSERT(a_fresh_from_store, $rose(cache_fresh) |-> (out_valid && out_data.cycle_stored),
    "cache turned fresh without a stored cycle")
  // A completed sampling end leaves the sensor asleep.
  `SDCS_ASSERT_NEXT(a_end_sleeps, advance && (result_next.cycle_stored || result_next.cycle_skipped),
    phase_state == sdcs_pkg::PH_SLEEP && !enable_level, "sampling end did not sleep")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the particle-sensor duty-cycle sampler: a directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;

  // Action code that the block must treat as a no-op.
  localparam logic [1:0] ACT_UNDEF = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Cycles allowed for the two register stages to empty.
  localparam int SETTLE_CYCLES = 6;

  // One input item as the sender sees it.
  typedef struct packed {
    logic [1:0]  action;
    logic        ok;
    logic [15:0] pm1;
    logic [15:0] pm25;
    logic [15:0] pm10;
  } frame_item_t;

  // One row of the directed table: either a register write or an item,
  // optionally with a result that is known without running the predictor.
  typedef struct {
    bit                wr;
    logic [2:0]        idx;
    logic [19:0]       val;
    frame_item_t       it;
    bit                pinned;
    sdcs_pkg::result_t res;
  } plan_row_t;

  typedef struct {
    bit                pinned;
    sdcs_pkg::result_t res;
  } pin_note_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata from bit 0: frame_ok(1), frame_pm1(16), frame_pm25(16),
  // frame_pm10(16), zero fill(7).
  logic [55:0] s_tdata = '0;
  // s_tuser: action(2).
  logic [1:0]  s_tuser = sdcs_pkg::ACT_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata from bit 0: fan_on(1), phase(2), frame_polled(1), cycle_stored(1),
  // cycle_skipped(1), reading_valid(1), out_pm1(16), out_pm25(16),
  // out_pm10(16), zero fill(1).
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = sdcs_pkg::REG_CYCLE_PERIOD;
  logic [19:0] cfg_data = '0;

  sensor_duty_cycle_sampler_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the configuration registers, updated as they are written.
  logic [19:0] cfg_cycle  = sdcs_pkg::RST_CYCLE_PERIOD;
  logic [19:0] cfg_warm   = sdcs_pkg::RST_WARMUP_TIME;
  logic [19:0] cfg_sample = sdcs_pkg::RST_SAMPLE_TIME;
  logic [19:0] cfg_poll   = sdcs_pkg::RST_POLL_PERIOD;
  logic [7:0]  cfg_min_good = sdcs_pkg::RST_MIN_GOOD_FRAMES;
  logic        cfg_present  = 1'b0;

  // Predicted sampler state, starting from the reset values.
  logic [1:0]  mdl_phase   = sdcs_pkg::PHASE_CODE_WARM;
  logic        mdl_fan     = 1'b1;
  logic [19:0] since_wake  = '0;
  logic [19:0] in_phase    = '0;
  logic [19:0] since_poll  = '0;
  logic [19:0] cache_age   = '0;
  logic [7:0]  good_frames = '0;
  logic [15:0] last_frame [3] = '{default: '0};
  logic [15:0] cache_vals [3] = '{default: '0};
  logic        cache_fresh = 1'b0;

  sdcs_pkg::result_t pending_results [$];
  pin_note_t         pinned_results [$];
  plan_row_t         directed_plan [$];

  int mismatches = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int src_idle_pct = 30;
  int snk_idle_pct = 58;

  // Elapsed-time counters stop at the all-ones value instead of wrapping.
  function automatic logic [19:0] bump(logic [19:0] v);
    return (v == '1) ? v : v + 20'd1;
  endfunction

  // Advances the predicted state by one item and returns the result it causes.
  task automatic predict_sampler_result(input frame_item_t it, output sdcs_pkg::result_t r);
    r = '0;
    case (it.action)
      sdcs_pkg::ACT_TICK: begin
        since_wake = bump(since_wake);
        in_phase   = bump(in_phase);
        since_poll = bump(since_poll);
        cache_age  = bump(cache_age);
        case (mdl_phase)
          sdcs_pkg::PHASE_CODE_SLEEP: begin
            if (since_wake >= cfg_cycle) begin
              mdl_fan    = 1'b1;
              since_wake = '0;
              in_phase   = '0;
              mdl_phase  = sdcs_pkg::PHASE_CODE_WARM;
            end
          end
          sdcs_pkg::PHASE_CODE_WARM: begin
            // Preloading the poll counter makes the first sampling tick poll.
            if (in_phase >= cfg_warm) begin
              good_frames = '0;
              since_poll  = cfg_poll;
              in_phase    = '0;
              mdl_phase   = sdcs_pkg::PHASE_CODE_SAMPLE;
            end
          end
          default: begin
            if (since_poll >= cfg_poll) begin
              since_poll     = '0;
              r.frame_polled = 1'b1;
              if (cfg_present && it.ok) begin
                last_frame[0] = it.pm1;
                last_frame[1] = it.pm25;
                last_frame[2] = it.pm10;
                if (good_frames < sdcs_pkg::GOOD_MAX) good_frames = good_frames + 8'd1;
              end
            end
            // The end of sampling is checked after the poll of the same tick.
            if (in_phase >= cfg_sample) begin
              if (good_frames >= cfg_min_good) begin
                cache_vals     = last_frame;
                cache_age      = '0;
                cache_fresh    = 1'b1;
                r.cycle_stored = 1'b1;
              end else begin
                r.cycle_skipped = 1'b1;
              end
              mdl_fan   = 1'b0;
              in_phase  = '0;
              mdl_phase = sdcs_pkg::PHASE_CODE_SLEEP;
            end
          end
        endcase
      end
      sdcs_pkg::ACT_READ: begin
        // A cache whose age has reached the cycle period is dropped on the read that finds it.
        if (cache_fresh) begin
          if (cache_age < cfg_cycle) begin
            r.reading_valid = 1'b1;
            r.pm1  = cache_vals[0];
            r.pm25 = cache_vals[1];
            r.pm10 = cache_vals[2];
          end else begin
            cache_fresh = 1'b0;
          end
        end
      end
      sdcs_pkg::ACT_SENT: cache_fresh = 1'b0;
      default: ;
    endcase
    r.fan_on = mdl_fan;
    r.phase  = mdl_phase;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      mismatches++;
    end
  endtask

  // Scoreboard. Both handshakes are sampled at the clock edge, before any of
  // the block's registers or the bench's drivers have moved, so the predictor
  // sees each accepted item exactly as the block does.
  frame_item_t       seen_item;
  sdcs_pkg::result_t predicted;
  sdcs_pkg::result_t observed;
  sdcs_pkg::result_t want;
  pin_note_t         note;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen_item.action = s_tuser;
        seen_item.ok     = s_tdata[0];
        seen_item.pm1    = s_tdata[16:1];
        seen_item.pm25   = s_tdata[32:17];
        seen_item.pm10   = s_tdata[48:33];
        predict_sampler_result(seen_item, predicted);
        note = pinned_results.pop_front();
        // Rows of the directed table with a typed-in result take that result.
        pending_results.push_back(note.pinned ? note.res : predicted);
      end
      if (m_tvalid && m_tready) begin
        observed = m_tdata;
        if (pending_results.size() == 0) begin
          $error("result transfer %0h arrived with nothing expected", m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("fan_on", want.fan_on, observed.fan_on);
          check_field("phase", want.phase, observed.phase);
          check_field("frame_polled", want.frame_polled, observed.frame_polled);
          check_field("cycle_stored", want.cycle_stored, observed.cycle_stored);
          check_field("cycle_skipped", want.cycle_skipped, observed.cycle_skipped);
          check_field("reading_valid", want.reading_valid, observed.reading_valid);
          check_field("out_pm1", want.pm1, observed.pm1);
          check_field("out_pm25", want.pm25, observed.pm25);
          check_field("out_pm10", want.pm10, observed.pm10);
          check_field("zero_fill", want.pad, observed.pad);
        end
        results_seen++;
      end
    end
  end

  // The receiver stalls at the rate of the current idling mode.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: any transfer on either side resets the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sensor_duty_cycle_sampler_core verification failed");
      $finish;
    end
  end

  function automatic sdcs_pkg::result_t quiet_result(logic fan, logic [1:0] ph);
    sdcs_pkg::result_t r;
    r = '0;
    r.fan_on = fan;
    r.phase  = ph;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [2:0] idx, logic [19:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.wr  = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] act, logic ok, logic [15:0] a,
                                         logic [15:0] b, logic [15:0] c);
    plan_row_t row;
    row = '{default: '0};
    row.it = '{action: act, ok: ok, pm1: a, pm25: b, pm10: c};
    return row;
  endfunction

  function automatic plan_row_t pinned_row(plan_row_t row, sdcs_pkg::result_t res);
    plan_row_t r;
    r = row;
    r.pinned = 1'b1;
    r.res = res;
    return r;
  endfunction

  // Concentrations lean on the extremes now and then.
  function automatic logic [15:0] pm_value();
    logic [15:0] v;
    case ($urandom_range(9))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Mostly ticks, so that the phase machine keeps moving; reads, mark-sent
  // items and the undefined action are sprinkled in between.
  function automatic frame_item_t random_item(int ok_pct);
    frame_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) it.action = sdcs_pkg::ACT_TICK;
    else if (pick < 89) it.action = sdcs_pkg::ACT_READ;
    else if (pick < 96) it.action = sdcs_pkg::ACT_SENT;
    else it.action = ACT_UNDEF;
    it.ok   = ($urandom_range(99) < ok_pct);
    it.pm1  = pm_value();
    it.pm25 = pm_value();
    it.pm10 = pm_value();
    return it;
  endfunction

  // Offers one item after a random gap and returns at the edge of its transfer.
  task automatic send_item(input frame_item_t it, input bit pinned,
                           input sdcs_pkg::result_t res);
    int gap;
    pin_note_t n;
    n.pinned = pinned;
    n.res = res;
    pinned_results.push_back(n);
    gap = 0;
    while (gap < 12 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.action;
    s_tdata  <= {7'd0, it.pm10, it.pm25, it.pm1, it.ok};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_accepted++;
  endtask

  // Stops offering items, waits for every result, then lets the pipeline settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (results_seen < items_accepted) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdcs_pkg::REG_CYCLE_PERIOD:    cfg_cycle    = val;
      sdcs_pkg::REG_WARMUP_TIME:     cfg_warm     = val;
      sdcs_pkg::REG_SAMPLE_TIME:     cfg_sample   = val;
      sdcs_pkg::REG_POLL_PERIOD:     cfg_poll     = val;
      sdcs_pkg::REG_MIN_GOOD_FRAMES: cfg_min_good = val[7:0];
      sdcs_pkg::REG_SENSOR_PRESENT:  cfg_present  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One test phase: a drain, a full set of register values, then a run of random items.
  task automatic run_phase(input logic [19:0] cyc, input logic [19:0] warm,
                           input logic [19:0] samp, input logic [19:0] poll,
                           input logic [7:0] min_good, input logic present,
                           input int count, input int ok_pct);
    drain_results();
    write_reg(sdcs_pkg::REG_CYCLE_PERIOD, cyc);
    write_reg(sdcs_pkg::REG_WARMUP_TIME, warm);
    write_reg(sdcs_pkg::REG_SAMPLE_TIME, samp);
    write_reg(sdcs_pkg::REG_POLL_PERIOD, poll);
    write_reg(sdcs_pkg::REG_MIN_GOOD_FRAMES, {12'd0, min_good});
    write_reg(sdcs_pkg::REG_SENSOR_PRESENT, {19'd0, present});
    repeat (count) send_item(random_item(ok_pct), 1'b0, '0);
  endtask

  initial begin
    // Right after reset the block is warming up with the fan on; nothing that
    // happens before warm-up ends can poll, store or report a reading.
    directed_plan.push_back(pinned_row(item_row(sdcs_pkg::ACT_READ, 1'b0, 16'h0, 16'h0,
                                                16'h0),
                                       quiet_result(1'b1, sdcs_pkg::PHASE_CODE_WARM)));
    directed_plan.push_back(pinned_row(item_row(ACT_UNDEF, 1'b1, 16'hFFFF, 16'hFFFF,
                                                16'hFFFF),
                                       quiet_result(1'b1, sdcs_pkg::PHASE_CODE_WARM)));
    directed_plan.push_back(pinned_row(item_row(sdcs_pkg::ACT_SENT, 1'b0, 16'h0, 16'h0,
                                                16'h0),
                                       quiet_result(1'b1, sdcs_pkg::PHASE_CODE_WARM)));
    directed_plan.push_back(pinned_row(item_row(sdcs_pkg::ACT_TICK, 1'b1, 16'hFFFF,
                                                16'hFFFF, 16'hFFFF),
                                       quiet_result(1'b1, sdcs_pkg::PHASE_CODE_WARM)));
    // All periods at zero: sampling is entered at once, polls every tick and
    // ends on its first tick; the cache is expired as soon as it is read.
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_SENSOR_PRESENT, 20'd1));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_WARMUP_TIME, 20'd0));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_SAMPLE_TIME, 20'd0));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_POLL_PERIOD, 20'd0));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_MIN_GOOD_FRAMES, 20'd0));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_CYCLE_PERIOD, 20'd0));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b1, 16'h1234, 16'hABCD, 16'hFFFF));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_READ, 1'b0, 16'h0, 16'h0, 16'h0));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_READ, 1'b0, 16'h0, 16'h0, 16'h0));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b0, 16'h0, 16'h0, 16'h0));
    // Largest cycle period, spaced polls and too few good frames: a skipped cycle.
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_CYCLE_PERIOD, 20'hFFFFF));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_WARMUP_TIME, 20'd1));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_SAMPLE_TIME, 20'd3));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_POLL_PERIOD, 20'd2));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_MIN_GOOD_FRAMES, 20'd2));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b1, 16'h0001, 16'h0002, 16'h0003));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b1, 16'h000A, 16'h000B, 16'h000C));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b1, 16'h5555, 16'hAAAA, 16'h5555));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_READ, 1'b0, 16'h0, 16'h0, 16'h0));
    // Short cycle with one good frame needed: a stored cycle, a valid read,
    // then mark-sent hides the reading again.
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_MIN_GOOD_FRAMES, 20'd1));
    directed_plan.push_back(cfg_row(sdcs_pkg::REG_CYCLE_PERIOD, 20'd5));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b0, 16'h0, 16'h0, 16'h0));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b0, 16'h0, 16'h0, 16'h0));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b0, 16'h1111, 16'h2222, 16'h3333));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_TICK, 1'b1, 16'h0001, 16'h8000, 16'h7FFF));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_READ, 1'b0, 16'h0, 16'h0, 16'h0));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_SENT, 1'b0, 16'h0, 16'h0, 16'h0));
    directed_plan.push_back(item_row(sdcs_pkg::ACT_READ, 1'b0, 16'h0, 16'h0, 16'h0));
    directed_plan.push_back(item_row(ACT_UNDEF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First idling mode: the sender gaps often, the receiver stalls more.
    src_idle_pct = 30;
    snk_idle_pct = 58;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].wr) begin
        drain_results();
        write_reg(directed_plan[i].idx, directed_plan[i].val);
      end else begin
        send_item(directed_plan[i].it, directed_plan[i].pinned, directed_plan[i].res);
      end
    end
    run_phase(20'd12, 20'd3, 20'd6, 20'd1, 8'd2, 1'b1, 100, 75);
    run_phase(20'd1, 20'd0, 20'd0, 20'd0, 8'd0, 1'b1, 50, 60);
    run_phase(20'($urandom_range(40, 1)), 20'($urandom_range(8)),
              20'($urandom_range(12)), 20'($urandom_range(4)),
              8'($urandom_range(4)), 1'b1, 70, 70);

    // Second idling mode: the roles are swapped.
    src_idle_pct = 58;
    snk_idle_pct = 30;
    // With no sensor fitted no poll is ever good.
    run_phase(20'($urandom_range(30, 1)), 20'($urandom_range(6)),
              20'($urandom_range(10)), 20'($urandom_range(3)),
              8'($urandom_range(2)), 1'b0, 50, 70);
    // A long sampling window that polls every tick drives the good-frame
    // count into saturation, which is just enough for the largest threshold.
    run_phase(20'd5, 20'd1, 20'd280, 20'd0, 8'd255, 1'b1, 400, 99);

    // Third idling mode: both sides run flat out.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 8'd255, 1'b1, 30, 50);
    run_phase(20'($urandom_range(40, 1)), 20'($urandom_range(8)),
              20'($urandom_range(12)), 20'($urandom_range(4)),
              8'($urandom_range(4)), 1'b1, 60, 70);
    run_phase(20'($urandom_range(20, 1)), 20'($urandom_range(4)),
              20'($urandom_range(8)), 20'($urandom_range(2)),
              8'($urandom_range(3)), 1'($urandom_range(1)), 60, 80);

    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sensor_duty_cycle_sampler_core verification clean");
    end else begin
      $display("sensor_duty_cycle_sampler_core verification failed");
    end
    $finish;
  end

endmodule
